// ===== rtl/iht_pkg.sv =====
// ----------------------------------------------------------------------------
// iht_pkg
// Shared types and codes for the interrupt handler table.
// ----------------------------------------------------------------------------
package iht_pkg;

	localparam int MODE_W = 2;
	localparam int LINE_W = 4;
	localparam int HID_W  = 32;
	localparam int KIND_W = 3;

	typedef enum logic [MODE_W-1:0] {
		MODE_REG      = 2'd0,
		MODE_UNREG    = 2'd1,
		MODE_DISPATCH = 2'd2,
		// spare code, the request is taken and dropped
		MODE_UNUSED   = 2'd3
	} mode_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_CALL       = 3'd0,
		KIND_NO_HANDLER = 3'd1,
		KIND_REGISTERED = 3'd2,
		KIND_TABLE_FULL = 3'd3,
		KIND_UNREG_OK   = 3'd4,
		KIND_NOT_REG    = 3'd5
	} kind_t;

endpackage

// ===== rtl/iht_if.sv =====
// ----------------------------------------------------------------------------
// iht_if
// Request and response channels of the interrupt handler table.
// ----------------------------------------------------------------------------
interface iht_req_if;
	import iht_pkg::*;

	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [LINE_W-1:0] irq_line;
	logic [HID_W-1:0]  handler_id;

	modport source (output valid, mode, irq_line, handler_id, input ready);
	modport sink   (input valid, mode, irq_line, handler_id, output ready);
endinterface

interface iht_rsp_if;
	import iht_pkg::*;

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [HID_W-1:0]  out_handler;
	logic [LINE_W-1:0] out_line;
	logic              last;

	modport source (output valid, kind, out_handler, out_line, last, input ready);
	modport sink   (input valid, kind, out_handler, out_line, last, output ready);
endinterface

// ===== rtl/interrupt_handler_table.sv =====
// ----------------------------------------------------------------------------
// interrupt_handler_table: register, unregister and dispatch of handler ids
// flow: the request beat reads the row, ST_LOAD registers the slot mask, ST_EMIT loads the response
// one request is taken at a time; dispatch emits one beat per filled slot, the others one beat
// a stalled response beat holds the engine
// reset: all lines read as empty at once (row valid flops), no clearing pass
// ----------------------------------------------------------------------------
module interrupt_handler_table #(
	parameter int NUM_LINES      = 16,
	parameter int SLOTS_PER_LINE = 8,
	parameter int ID_WIDTH       = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	iht_req_if.sink   req,
	iht_rsp_if.source rsp
);
	import iht_pkg::*;

	// one memory row holds all slots of one interrupt line
	localparam int ROW_BITS = SLOTS_PER_LINE * ID_WIDTH;
	localparam int ROW_W    = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_EMIT
	} state_t;

	// row storage, one synchronous read port and one write port
	logic [ROW_BITS-1:0]       mem_q [NUM_LINES];
	logic [ROW_BITS-1:0]       row_s1;
	logic                      vld_s1;
	// a row never written since reset reads as all empty
	logic [NUM_LINES-1:0]      row_vld_q;

	state_t                    state_q;
	mode_t                     mode_q;
	logic [LINE_W-1:0]         line_q;
	logic [ID_WIDTH-1:0]       id_q;
	logic [ROW_W-1:0]          addr_q;
	logic                      line_ok_q;
	logic [SLOTS_PER_LINE-1:0] mask_q;

	logic                      out_valid_q;
	kind_t                     kind_q;
	logic [HID_W-1:0]          handler_q;
	logic [LINE_W-1:0]         out_line_q;
	logic                      last_q;

	logic                      rd_en;
	logic [ROW_W+LINE_W-1:0]   line_ext;
	logic [ROW_W-1:0]          rd_addr;
	logic                      line_ok;
	logic [ID_WIDTH+HID_W-1:0] in_id_ext;
	logic [ID_WIDTH-1:0]       in_id;

	logic [ROW_BITS-1:0]       row_eff;
	logic [SLOTS_PER_LINE-1:0] mask_d;
	logic [SLOTS_PER_LINE-1:0] pick;
	logic [SLOTS_PER_LINE-1:0] rest;
	logic [ID_WIDTH-1:0]       pick_id;
	logic [ROW_BITS-1:0]       wr_row;
	logic                      wr_en;
	logic                      can_load;
	logic                      emit_go;
	logic [ID_WIDTH-1:0]       rsp_id;
	logic [ID_WIDTH+HID_W-1:0] rsp_id_ext;

	// request side: only one item is in flight, taken while the engine idles
	assign req.ready = (state_q == ST_IDLE);
	assign rd_en     = req.valid && req.ready;

	// lines past the table never change it
	assign line_ext  = {{ROW_W{1'b0}}, req.irq_line};
	assign rd_addr   = line_ext[ROW_W-1:0];
	assign line_ok   = (line_ext < (ROW_W+LINE_W)'(NUM_LINES));

	// ids are reduced to the stored width
	assign in_id_ext = {{ID_WIDTH{1'b0}}, req.handler_id};
	assign in_id     = in_id_ext[ID_WIDTH-1:0];

	// read data gated by the row valid flop
	assign row_eff   = vld_s1 ? row_s1 : '0;

	// slot masks: empty slots for register, matching slots for unregister,
	// filled slots for dispatch; compares are independent per slot
	// a line past the table has no usable slot at all
	always_comb begin
		for (int s = 0; s < SLOTS_PER_LINE; s++) begin
			if (!line_ok_q) begin
				mask_d[s] = 1'b0;
			end else begin
				case (mode_q)
					MODE_REG:      mask_d[s] = (row_eff[s*ID_WIDTH +: ID_WIDTH] == '0);
					MODE_UNREG:    mask_d[s] = (row_eff[s*ID_WIDTH +: ID_WIDTH] == id_q);
					MODE_DISPATCH: mask_d[s] = (row_eff[s*ID_WIDTH +: ID_WIDTH] != '0);
					default:       mask_d[s] = 1'b0;
				endcase
			end
		end
	end

	// lowest remaining slot, one-hot, and what is left after it
	assign pick = mask_q & (~mask_q + SLOTS_PER_LINE'(1));
	assign rest = mask_q & ~pick;

	// slot select and write-back row built from the one-hot pick
	always_comb begin
		pick_id = '0;
		for (int s = 0; s < SLOTS_PER_LINE; s++) begin
			if (pick[s]) begin
				pick_id = pick_id | row_eff[s*ID_WIDTH +: ID_WIDTH];
				wr_row[s*ID_WIDTH +: ID_WIDTH] = (mode_q == MODE_REG) ? id_q : '0;
			end else begin
				wr_row[s*ID_WIDTH +: ID_WIDTH] = row_eff[s*ID_WIDTH +: ID_WIDTH];
			end
		end
	end

	// the response register is free or drains this cycle
	assign can_load = !out_valid_q || rsp.ready;
	assign emit_go  = (state_q == ST_EMIT) && can_load;

	// register and unregister write back at most once, when they answer with a slot found
	assign wr_en = emit_go && (mask_q != '0) && (mode_q != MODE_DISPATCH);

	assign rsp_id     = (mode_q == MODE_DISPATCH) ? pick_id : id_q;
	assign rsp_id_ext = {{HID_W{1'b0}}, rsp_id};

	// row memory; the write lands before the next request can read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[addr_q] <= wr_row;
		end
		if (rd_en) begin
			row_s1 <= mem_q[rd_addr];
		end
	end

	// control engine and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_vld_q   <= '0;
			out_valid_q <= 1'b0;
			vld_s1      <= 1'b0;
			mode_q      <= MODE_REG;
			line_q      <= '0;
			id_q        <= '0;
			addr_q      <= '0;
			line_ok_q   <= 1'b0;
			mask_q      <= '0;
			kind_q      <= KIND_CALL;
			handler_q   <= '0;
			out_line_q  <= '0;
			last_q      <= 1'b0;
		end else begin
			// a new beat replaces the one leaving, else the register drains
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (wr_en) begin
				row_vld_q[addr_q] <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					// the unused mode is taken and dropped
					if (rd_en && (req.mode != MODE_UNUSED)) begin
						mode_q    <= mode_t'(req.mode);
						line_q    <= req.irq_line;
						id_q      <= in_id;
						addr_q    <= rd_addr;
						line_ok_q <= line_ok;
						vld_s1    <= line_ok && row_vld_q[rd_addr];
						state_q   <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					mask_q  <= mask_d;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (can_load) begin
						out_line_q <= line_q;
						case (mode_q)
							MODE_REG: begin
								kind_q    <= (mask_q != '0) ? KIND_REGISTERED : KIND_TABLE_FULL;
								handler_q <= rsp_id_ext[HID_W-1:0];
								last_q    <= 1'b1;
								state_q   <= ST_IDLE;
							end
							MODE_UNREG: begin
								kind_q    <= (mask_q != '0) ? KIND_UNREG_OK : KIND_NOT_REG;
								handler_q <= rsp_id_ext[HID_W-1:0];
								last_q    <= 1'b1;
								state_q   <= ST_IDLE;
							end
							default: begin
								// dispatch: one call beat per filled slot, or a fault
								if (mask_q == '0) begin
									kind_q    <= KIND_NO_HANDLER;
									handler_q <= '0;
									last_q    <= 1'b1;
									state_q   <= ST_IDLE;
								end else begin
									kind_q    <= KIND_CALL;
									handler_q <= rsp_id_ext[HID_W-1:0];
									mask_q    <= rest;
									last_q    <= (rest == '0);
									state_q   <= (rest != '0) ? ST_EMIT : ST_IDLE;
								end
							end
						endcase
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.kind        = kind_q;
	assign rsp.out_handler = handler_q;
	assign rsp.out_line    = out_line_q;
	assign rsp.last        = last_q;

endmodule
